/* rtl/lcd4_pkg.sv */
// Shared types, codes and constants for the 4-bit character LCD interface.
`timescale 1ns / 1ps

package lcd4_pkg;

   localparam int WAIT_W      = 16;
   localparam int SETTLE_W    = 7;
   localparam int STEP_W      = 4;
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
   localparam logic [STEP_W-1:0] INIT_BYTE_STEP = 4'd4;

   localparam logic [WAIT_W-1:0]   POWER_UP_RST = 16'd10000;
   localparam logic [WAIT_W-1:0]   INIT_STEP_RST = 16'd2000;
   localparam logic [WAIT_W-1:0]   CLEAR_RST    = 16'd1000;
   localparam logic [SETTLE_W-1:0] SETTLE_RST   = 7'd20;

   localparam logic [7:0] LCD_CLEAR     = 8'h01;
   localparam logic [7:0] DDRAM_SET     = 8'h80;
   localparam logic [7:0] DIGIT_BASE    = 8'h30;
   localparam logic [7:0] ROW2_OFFSET   = 8'h40;
   localparam logic [7:0] ROW3_OFFSET   = 8'd20;
   localparam logic [7:0] ROW4_OFFSET   = 8'd84;
   localparam logic [3:0] INIT_NIB_8BIT = 4'h3;
   localparam logic [3:0] INIT_NIB_4BIT = 4'h2;

   typedef enum logic [2:0] {
      CMD_CHAR   = 3'd0,
      CMD_BYTE   = 3'd1,
      CMD_CURSOR = 3'd2,
      CMD_INIT   = 3'd3,
      CMD_CLEAR  = 3'd4,
      CMD_DIGIT  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      REG_POWER_UP  = 2'd0,
      REG_INIT_STEP = 2'd1,
      REG_CLEAR     = 2'd2,
      REG_SETTLE    = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BYTE,
      ST_INIT
   } back_state_type;

   // one queued job: a single byte, or the whole init run
   typedef struct packed {
      logic       init;
      logic       rs;
      logic [7:0] data;
   } desc_type;

   typedef struct packed {
      logic [WAIT_W-1:0]   power_up_wait;
      logic [WAIT_W-1:0]   init_step_wait;
      logic [WAIT_W-1:0]   clear_wait;
      logic [SETTLE_W-1:0] byte_settle;
   } cfg_type;

   // function set 4-bit/2-line, display on, clear, entry mode
   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h28;
         2'd1:    b = 8'h0C;
         2'd2:    b = 8'h01;
         default: b = 8'h06;
      endcase
      return b;
   endfunction

endpackage

/* rtl/lcd4_front.sv */
// Request decoder: turns a request into a queued byte or init job.
`timescale 1ns / 1ps

module lcd4_front import lcd4_pkg::*; (
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [2:0] cmd,
   input  logic [7:0] value,
   input  logic [2:0] row,
   input  logic [5:0] column,
   input  logic       q_full,
   output logic       q_push,
   output desc_type   q_desc
);

   logic       has_job;
   logic [7:0] offset;
   logic [7:0] addr;
   logic       row_ok;

   assign req_tready = ~q_full & ~reset;

   always_comb begin
      row_ok = 1'b1;
      case (row)
         3'd1:    offset = 8'd0;
         3'd2:    offset = ROW2_OFFSET;
         3'd3:    offset = ROW3_OFFSET;
         3'd4:    offset = ROW4_OFFSET;
         default: begin
            offset = 8'd0;
            row_ok = 1'b0;
         end
      endcase
      // column counts from 1; wraps mod 256
      addr = row_ok ? (offset + {2'b00, column} - 8'd1) : 8'd0;
   end

   always_comb begin
      has_job     = 1'b1;
      q_desc.init = 1'b0;
      q_desc.rs   = 1'b0;
      q_desc.data = value;
      case (cmd)
         CMD_CHAR:   q_desc.rs = 1'b1;
         CMD_BYTE:   q_desc.rs = 1'b0;
         CMD_CURSOR: q_desc.data = DDRAM_SET + addr;
         CMD_INIT:   q_desc.init = 1'b1;
         CMD_CLEAR:  q_desc.data = LCD_CLEAR;
         CMD_DIGIT: begin
            q_desc.rs   = 1'b1;
            q_desc.data = DIGIT_BASE + value;
            has_job     = (value <= 8'd9);
         end
         default:    has_job = 1'b0;
      endcase
   end

   // requests with no strobes are taken and dropped
   assign q_push = req_tvalid & req_tready & has_job;

endmodule

/* rtl/lcd4_queue.sv */
// Small job queue between the request decoder and the strobe sequencer.
`timescale 1ns / 1ps

module lcd4_queue import lcd4_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output desc_type head
);

   desc_type               slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

/* rtl/lcd4_back.sv */
// Strobe sequencer: walks each job nibble by nibble into the output register.
`timescale 1ns / 1ps

module lcd4_back import lcd4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_not_empty,
   input  desc_type          q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              reg_select,
   output logic [3:0]        nibble,
   output logic [WAIT_W-1:0] wait_units,
   output logic              last
);

   back_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   desc_type           job_ff, job_in;

   logic               out_valid_ff;
   logic               out_rs_ff, out_last_ff;
   logic [3:0]         out_nib_ff;
   logic [WAIT_W-1:0]  out_wait_ff;

   logic               out_free, emit, load;
   logic               s_rs, s_last;
   logic [3:0]         s_nib;
   logic [WAIT_W-1:0]  s_wait;
   logic [WAIT_W-1:0]  settle_ext;
   logic [WAIT_W:0]    clear_sum;
   logic [1:0]         ib_idx;
   logic [7:0]         ib;

   assign out_free = ~out_valid_ff | rsp_tready;
   assign emit     = (state_ff != ST_IDLE) & out_free;
   assign load     = q_not_empty & ((state_ff == ST_IDLE) | (emit & s_last));
   assign q_pop    = load;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      if (load) begin
         state_in = q_head.init ? ST_INIT : ST_BYTE;
         step_in  = '0;
         job_in   = q_head;
      end else if (emit) begin
         if (s_last) begin
            state_in = ST_IDLE;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   // strobe contents for the current step
   always_comb begin
      settle_ext = {{(WAIT_W-SETTLE_W){1'b0}}, cfg.byte_settle};
      clear_sum  = {1'b0, cfg.clear_wait} + {1'b0, settle_ext};
      ib_idx     = 2'(step_ff[STEP_W-1:1] - 3'd2);
      ib         = init_byte(ib_idx);
      s_rs       = 1'b0;
      s_nib      = '0;
      s_wait     = '0;
      s_last     = 1'b0;
      case (state_ff)
         ST_BYTE: begin
            s_rs   = job_ff.rs;
            s_last = (step_ff == BYTE_LAST_STEP);
            if (step_ff[0]) begin
               s_nib = job_ff.data[3:0];
            end else begin
               s_nib  = job_ff.data[7:4];
               s_wait = settle_ext;
            end
         end
         ST_INIT: begin
            s_last = (step_ff == INIT_LAST_STEP);
            if (step_ff < INIT_BYTE_STEP) begin
               s_nib  = (step_ff == 4'd3) ? INIT_NIB_4BIT : INIT_NIB_8BIT;
               s_wait = (step_ff == 4'd0) ? cfg.power_up_wait : cfg.init_step_wait;
            end else if (step_ff[0]) begin
               s_nib = ib[3:0];
            end else begin
               s_nib = ib[7:4];
               if (ib_idx == 2'd3) begin
                  // entry mode byte also carries the clear delay, saturated
                  s_wait = clear_sum[WAIT_W] ? {WAIT_W{1'b1}} : clear_sum[WAIT_W-1:0];
               end else begin
                  s_wait = settle_ext;
               end
            end
         end
         default: begin
            s_nib = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (out_free) begin
            out_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         out_rs_ff   <= s_rs;
         out_nib_ff  <= s_nib;
         out_wait_ff <= s_wait;
         out_last_ff <= s_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign reg_select = out_rs_ff;
   assign nibble     = out_nib_ff;
   assign wait_units = out_wait_ff;
   assign last       = out_last_ff;

endmodule

/* rtl/char_lcd_4bit_interface.sv */
// Top level of the 4-bit character LCD interface: registers, decoder, queue, sequencer.
`timescale 1ns / 1ps

// Converts LCD requests into a stream of 4-bit bus strobes, each with its
// register-select bit and the wait to hold before it. A char, command,
// cursor move, clear or digit gives two strobes (high nibble first); init
// gives twelve; an unused code or a digit above nine gives none. The
// sequencer puts out one strobe per clock while the strobe output is not
// stalled by rsp_tready; a two-entry job queue lets requests be taken
// while the sequencer is busy. The wait registers are written through
// the APB port at byte addresses 0, 4, 8 and 12 and read back there.

module char_lcd_4bit_interface import lcd4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request transfers
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // value[7:0], row[10:8], column[16:11], zero pad
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   // strobe transfers
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // nibble[3:0], wait_units[19:4], zero pad
   output logic        rsp_tuser,   // reg_select
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type           cfg_ff, cfg_in;
   reg_index_type     csr_idx;
   logic              csr_wr;

   logic              q_push, q_pop, q_full, q_not_empty;
   desc_type          q_desc, q_head;
   logic              reg_select, last;
   logic [3:0]        nibble;
   logic [WAIT_W-1:0] wait_units;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_POWER_UP:  cfg_in.power_up_wait  = csr_pwdata[WAIT_W-1:0];
            REG_INIT_STEP: cfg_in.init_step_wait = csr_pwdata[WAIT_W-1:0];
            REG_CLEAR:     cfg_in.clear_wait     = csr_pwdata[WAIT_W-1:0];
            REG_SETTLE:    cfg_in.byte_settle    = csr_pwdata[SETTLE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_POWER_UP:  csr_prdata = {16'd0, cfg_ff.power_up_wait};
         REG_INIT_STEP: csr_prdata = {16'd0, cfg_ff.init_step_wait};
         REG_CLEAR:     csr_prdata = {16'd0, cfg_ff.clear_wait};
         REG_SETTLE:    csr_prdata = {25'd0, cfg_ff.byte_settle};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up_wait  <= POWER_UP_RST;
         cfg_ff.init_step_wait <= INIT_STEP_RST;
         cfg_ff.clear_wait     <= CLEAR_RST;
         cfg_ff.byte_settle    <= SETTLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcd4_front u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (req_tuser),
      .value      (req_tdata[7:0]),
      .row        (req_tdata[10:8]),
      .column     (req_tdata[16:11]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_desc     (q_desc)
   );

   lcd4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   lcd4_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .reg_select  (reg_select),
      .nibble      (nibble),
      .wait_units  (wait_units),
      .last        (last)
   );

   assign rsp_tdata = {4'd0, wait_units, nibble};
   assign rsp_tuser = reg_select;
   assign rsp_tlast = last;

endmodule
